>>> rtl/gsp_pkg.sv
// gsp_pkg: shared types, constants and helper functions for the guid string parser
// used by gsp_decode and guid_string_parser; no dependencies
package gsp_pkg;

	// item kinds carried on s_tuser
	localparam logic [1:0] MODE_CHAR     = 2'd0;
	localparam logic [1:0] MODE_END      = 2'd1;
	localparam logic [1:0] MODE_NULL_STR = 2'd2;
	localparam logic [1:0] MODE_NULL_DST = 2'd3;

	// result status codes
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_BAD_ARG   = 2'd1;
	localparam logic [1:0] STATUS_MALFORMED = 2'd2;

	// text layout
	localparam int          GUID_BYTES   = 16;
	localparam logic [5:0]  TEXT_LEN     = 6'd38;
	localparam logic [5:0]  COUNT_CAP    = 6'd39;
	localparam logic [5:0]  POS_OPEN     = 6'd0;
	localparam logic [5:0]  POS_DATA1    = 6'd1;
	localparam logic [5:0]  POS_DATA1_END = 6'd8;
	localparam logic [5:0]  POS_SEP1     = 6'd9;
	localparam logic [5:0]  POS_SEP2     = 6'd14;
	localparam logic [5:0]  POS_SEP3     = 6'd19;
	localparam logic [5:0]  POS_D4_0     = 6'd21;
	localparam logic [5:0]  POS_SEP4     = 6'd24;
	localparam logic [5:0]  POS_TAIL     = 6'd26;
	localparam logic [5:0]  POS_CLOSE    = 6'd37;

	// character codes
	localparam logic [15:0] CH_NUL    = 16'h0000;
	localparam logic [15:0] CH_LBRACE = 16'h007B;
	localparam logic [15:0] CH_RBRACE = 16'h007D;
	localparam logic [15:0] CH_DASH   = 16'h002D;

	// output word width: 64 + 64 + 16 + 2 bits, padded to whole bytes
	localparam int OUT_BITS = 152;

	typedef struct packed {
		logic [5:0]              count;
		logic [31:0]             acc;
		logic [GUID_BYTES-1:0][7:0] bytes;
		logic [GUID_BYTES-1:0]   written;
		logic                    failed;
	} parse_state_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] written_mask;
		logic [63:0] guid_high;
		logic [63:0] guid_low;
	} parse_result_t;

	// returns {is_hex, value}
	function automatic logic [4:0] hex_decode(input logic [15:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 16'h0030 && c <= 16'h0039)
			r = {1'b1, c[3:0]};
		else if ((c >= 16'h0041 && c <= 16'h0046) || (c >= 16'h0061 && c <= 16'h0066))
			r = {1'b1, c[3:0] + 4'd9};
		return r;
	endfunction

endpackage

>>> rtl/gsp_decode.sv
// gsp_decode: per-item next-state and result logic of the guid string parser
// depends on gsp_pkg
module gsp_decode import gsp_pkg::*; (
	input  parse_state_t  cur,
	input  logic [1:0]    mode,
	input  logic [15:0]   character,
	output parse_state_t  nxt,
	output logic          is_end,
	output parse_result_t result
);

	logic [4:0]  hx;
	logic [5:0]  p;
	logic [31:0] acc_base;
	logic [31:0] acc_new;
	logic [3:0]  tail_idx;
	logic        take;

	assign hx       = hex_decode(character);
	assign p        = cur.count;
	assign is_end   = !(mode == MODE_CHAR && character != CH_NUL);
	assign take     = (p < TEXT_LEN) && !cur.failed;
	assign acc_base = (p == POS_DATA1) ? 32'd0 : cur.acc;
	assign acc_new  = {acc_base[27:0], hx[3:0]};
	// tail bytes 10..15 sit at even positions 26..36
	assign tail_idx = 4'(p[5:1] - 5'd3);

	// state update for one item: a character advances the parse, an ending item clears it
	always_comb begin
		nxt = cur;
		if (is_end) begin
			nxt = '0;
		end else begin
			if (take) begin
				if (p == POS_OPEN) begin
					if (character != CH_LBRACE)
						nxt.failed = 1'b1;
				end else if (p == POS_CLOSE) begin
					if (character != CH_RBRACE)
						nxt.failed = 1'b1;
				end else begin
					// data1 is cleared at its first digit
					if (p == POS_DATA1) begin
						nxt.acc = 32'd0;
						nxt.bytes[3:0] = '0;
						nxt.written[3:0] = 4'hF;
					end
					if (p == POS_SEP1 || p == POS_SEP2 || p == POS_SEP3 || p == POS_SEP4) begin
						if (character != CH_DASH) begin
							nxt.failed = 1'b1;
						end else begin
							if (p == POS_SEP2) begin
								nxt.bytes[4] = cur.acc[7:0];
								nxt.bytes[5] = cur.acc[15:8];
								nxt.written[5:4] = 2'b11;
							end else if (p == POS_SEP3) begin
								nxt.bytes[6] = cur.acc[7:0];
								nxt.bytes[7] = cur.acc[15:8];
								nxt.written[7:6] = 2'b11;
							end else if (p == POS_SEP4) begin
								nxt.bytes[9] = cur.acc[7:0];
								nxt.written[9] = 1'b1;
							end
							nxt.acc = 32'd0;
						end
					end else if (!hx[4]) begin
						nxt.failed = 1'b1;
					end else begin
						nxt.acc = acc_new;
						if (p <= POS_DATA1_END) begin
							nxt.bytes[3:0] = acc_new;
							nxt.written[3:0] = 4'hF;
						end else if (p == POS_D4_0) begin
							nxt.bytes[8] = acc_new[7:0];
							nxt.written[8] = 1'b1;
							nxt.acc = 32'd0;
						end else if (p >= POS_TAIL && !p[0]) begin
							nxt.bytes[tail_idx] = acc_new[7:0];
							nxt.written[tail_idx] = 1'b1;
							nxt.acc = 32'd0;
						end
					end
				end
			end
			if (p < COUNT_CAP)
				nxt.count = p + 6'd1;
		end
	end

	// result for an ending item
	always_comb begin
		result = '0;
		if (mode == MODE_NULL_STR) begin
			result.written_mask = 16'hFFFF;
			result.status = STATUS_OK;
		end else if (mode == MODE_NULL_DST || p != TEXT_LEN) begin
			result.status = STATUS_BAD_ARG;
		end else begin
			result.guid_low     = cur.bytes[7:0];
			result.guid_high    = cur.bytes[15:8];
			result.written_mask = cur.written;
			result.status       = cur.failed ? STATUS_MALFORMED : STATUS_OK;
		end
	end

endmodule

>>> rtl/guid_string_parser.sv
// Streaming parser for a braced GUID string, one 16-bit character per input word.
// s_tuser gives the word kind (character, end of string, null string, null
// destination); a character code of zero also ends the string. Each ending word
// yields one output word with the sixteen GUID bytes, the mask of bytes written
// and a status; character words yield nothing. The block takes one word per
// cycle when not stalled: a word sits in the input register while the decode
// logic updates the parse state, and an ending word's result is then written
// into the output register, which drives m_tvalid. The only stall comes from
// the output register when a result is held by m_tready. Parse state is
// cleared after every result.
module guid_string_parser import gsp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [15:0]         s_tdata,   // character [15:0]
	input  logic [1:0]          s_tuser,   // mode [1:0]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OUT_BITS-1:0] m_tdata    // guid_low [63:0], guid_high [127:64],
	                                       // written_mask [143:128], status [145:144]
);

	logic          valid_s1;
	logic [1:0]    mode_s1;
	logic [15:0]   char_s1;
	parse_state_t  state_q;
	parse_state_t  state_nxt;
	logic          is_end;
	parse_result_t result;
	parse_result_t result_q;
	logic          out_valid_q;
	logic          out_free;
	logic          advance;

	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && (!is_end || out_free);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			mode_s1 <= s_tuser;
			char_s1 <= s_tdata;
		end
	end

	gsp_decode u_decode (
		.cur       (state_q),
		.mode      (mode_s1),
		.character (char_s1),
		.nxt       (state_nxt),
		.is_end    (is_end),
		.result    (result)
	);

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && is_end;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_end)
			result_q <= result;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_BITS - $bits(parse_result_t)){1'b0}}, result_q};

endmodule
